### sv/hcb_pkg.sv
// ----------------------------------------------------------------------------
// Horizontal crossfade blend package
// Shared constants and types for the crossfade blend core and its step unit.
// ----------------------------------------------------------------------------
package hcb_pkg;

   localparam int PIX_WIDTH         = 8;
   localparam int NUM_CHAN          = 3;
   localparam int CFG_WIDTH         = 13;
   localparam int SPLIT_PARTS       = 3;
   localparam int DEFAULT_MAX_WIDTH = 4096;
   localparam logic [CFG_WIDTH-1:0] IMAGE_WIDTH_RESET = CFG_WIDTH'(640);

   typedef logic [PIX_WIDTH-1:0] chan_type;
   typedef chan_type [NUM_CHAN-1:0] rgb_type;

   // Sequencer states, one-hot
   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_DIV   = 5'b00010,
      ST_SPLIT = 5'b00100,
      ST_STEP  = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

endpackage

### sv/horizontal_crossfade_blend_core.sv
// ----------------------------------------------------------------------------
// Horizontal crossfade blend core
// Blends co-located pixels of two images: A on the left third, B on the right,
// a subdivision ramp between them.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one pixel pair per transfer (req_valid high, req_stall low).
//   rsp_* returns one blended pixel per pair, with rsp_row_end marking the
//   last column of a row. csr_image_width sets the row width; csr_ready is
//   always high, and the write is taken at once.
//   After acceptance the core divides the width by three, then picks the
//   region; middle columns run subdivision passes until one ends. The result
//   then loads the output register once it is free; edge columns skip the
//   passes. The subdivision step unit is shared over the passes, so one
//   pixel is in work at a time; req_stall is high from acceptance until the
//   result moves to the output register.
//   The output register holds a finished pixel while rsp_stall is high; the
//   next pair is still accepted and worked on meanwhile.
//   Reset (synchronous) sets the width to 640, the column to 0 and empties
//   the output register.
// ----------------------------------------------------------------------------
module horizontal_crossfade_blend_core #(
   parameter int MAX_WIDTH = hcb_pkg::DEFAULT_MAX_WIDTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [hcb_pkg::CFG_WIDTH-1:0]  csr_image_width,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [hcb_pkg::PIX_WIDTH-1:0]  req_a_red,
   input  logic [hcb_pkg::PIX_WIDTH-1:0]  req_a_green,
   input  logic [hcb_pkg::PIX_WIDTH-1:0]  req_a_blue,
   input  logic [hcb_pkg::PIX_WIDTH-1:0]  req_b_red,
   input  logic [hcb_pkg::PIX_WIDTH-1:0]  req_b_green,
   input  logic [hcb_pkg::PIX_WIDTH-1:0]  req_b_blue,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [hcb_pkg::PIX_WIDTH-1:0]  rsp_out_red,
   output logic [hcb_pkg::PIX_WIDTH-1:0]  rsp_out_green,
   output logic [hcb_pkg::PIX_WIDTH-1:0]  rsp_out_blue,
   output logic                           rsp_row_end
);
   import hcb_pkg::*;

   localparam int WW   = $clog2(MAX_WIDTH + 1);
   localparam int CW   = $clog2(MAX_WIDTH);
   localparam int CMPW = (WW > CFG_WIDTH) ? WW : CFG_WIDTH;
   localparam int RS   = WW + 2;
   localparam int PRW  = WW + RS;
   localparam logic [RS-1:0] RECIP = RS'(((2 ** RS) + SPLIT_PARTS - 1) / SPLIT_PARTS);

   logic [CFG_WIDTH-1:0] image_width_ff;
   logic [CW-1:0]        column_ff, column_in;
   logic [CW-1:0]        col_ff;
   logic [WW-1:0]        width_ff;
   logic [WW-1:0]        left_ff;
   logic [WW-1:0]        t_ff, t_in;
   logic [WW-1:0]        p_ff, p_in;
   rgb_type              lo_ff, lo_in;
   rgb_type              hi_ff, hi_in;
   rgb_type              res_ff, res_in;
   logic                 row_end_ff;
   state_type            state_ff, state_in;

   logic                 rsp_valid_ff;
   rgb_type              rsp_pix_ff;
   logic                 rsp_row_end_ff;

   logic [CMPW-1:0]      cfg_ext;
   logic [WW-1:0]        eff_width;
   logic [WW-1:0]        col_plus;
   logic                 row_end;
   logic                 accept;
   logic                 out_free;
   logic [PRW-1:0]       prod;
   logic [WW-1:0]        left_calc;
   logic [WW-1:0]        right;
   logic [WW-1:0]        col_ext;

   logic                 step_done;
   rgb_type              step_res;
   logic [WW-1:0]        step_t, step_p;
   rgb_type              step_lo, step_hi;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff <= IMAGE_WIDTH_RESET;
      end else if (csr_valid && csr_ready) begin
         image_width_ff <= csr_image_width;
      end
   end

   // effective width: zero reads as one, saturate at MAX_WIDTH
   assign cfg_ext = CMPW'(image_width_ff);
   always_comb begin
      priority if (cfg_ext == '0) begin
         eff_width = WW'(1);
      end else if (cfg_ext > CMPW'(MAX_WIDTH)) begin
         eff_width = WW'(MAX_WIDTH);
      end else begin
         eff_width = WW'(cfg_ext);
      end
   end

   assign accept   = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign col_plus = WW'(column_ff) + WW'(1);
   assign row_end  = (col_plus >= eff_width);
   assign column_in = row_end ? '0 : CW'(col_plus);

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= '0;
      end else if (accept) begin
         column_ff <= column_in;
      end
   end

   // divide by three through a reciprocal multiply
   assign prod      = PRW'(width_ff) * PRW'(RECIP);
   assign left_calc = WW'(prod >> RS);
   assign right     = width_ff - left_ff;
   assign col_ext   = WW'(col_ff);

   hcb_step #(
      .PW (WW)
   ) u_step (
      .t       (t_ff),
      .p       (p_ff),
      .lo      (lo_ff),
      .hi      (hi_ff),
      .done    (step_done),
      .result  (step_res),
      .t_next  (step_t),
      .p_next  (step_p),
      .lo_next (step_lo),
      .hi_next (step_hi)
   );

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      t_in     = t_ff;
      p_in     = p_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      res_in   = res_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               lo_in    = {req_a_blue, req_a_green, req_a_red};
               hi_in    = {req_b_blue, req_b_green, req_b_red};
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            state_in = ST_SPLIT;
         end
         ST_SPLIT: begin
            priority if (col_ext < left_ff) begin
               res_in   = lo_ff;
               state_in = ST_DONE;
            end else if (col_ext >= right) begin
               res_in   = hi_ff;
               state_in = ST_DONE;
            end else begin
               t_in     = col_ext - left_ff;
               p_in     = right - left_ff;
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            if (step_done) begin
               res_in   = step_res;
               state_in = ST_DONE;
            end else begin
               t_in  = step_t;
               p_in  = step_p;
               lo_in = step_lo;
               hi_in = step_hi;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      t_ff   <= t_in;
      p_ff   <= p_in;
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      res_ff <= res_in;
      if (accept) begin
         col_ff     <= column_ff;
         width_ff   <= eff_width;
         row_end_ff <= row_end;
      end
      if (state_ff == ST_DIV) begin
         left_ff <= left_calc;
      end
   end

   // output register: hold while the receiver stalls
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((state_ff == ST_DONE) && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == ST_DONE) && out_free) begin
         rsp_pix_ff     <= res_ff;
         rsp_row_end_ff <= row_end_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_red   = rsp_pix_ff[0];
   assign rsp_out_green = rsp_pix_ff[1];
   assign rsp_out_blue  = rsp_pix_ff[2];
   assign rsp_row_end   = rsp_row_end_ff;

endmodule

### sv/hcb_step.sv
// ----------------------------------------------------------------------------
// Crossfade subdivision step
// One pass of the binary-subdivision interpolation for all three channels;
// the position and scale decisions are shared by the channels.
// ----------------------------------------------------------------------------
module hcb_step #(
   parameter int PW = 13
) (
   input  logic [PW-1:0]    t,
   input  logic [PW-1:0]    p,
   input  hcb_pkg::rgb_type lo,
   input  hcb_pkg::rgb_type hi,
   output logic             done,
   output hcb_pkg::rgb_type result,
   output logic [PW-1:0]    t_next,
   output logic [PW-1:0]    p_next,
   output hcb_pkg::rgb_type lo_next,
   output hcb_pkg::rgb_type hi_next
);
   import hcb_pkg::*;

   logic [PW-1:0]  half;
   logic [PW:0]    half_up;
   logic [PW:0]    p_inc;
   rgb_type        mid;
   logic [PIX_WIDTH:0] sum [NUM_CHAN];

   assign half    = p >> 1;
   assign p_inc   = {1'b0, p} + (PW+1)'(1);
   assign half_up = p_inc >> 1;

   always_comb begin
      for (int c = 0; c < NUM_CHAN; c++) begin
         sum[c] = {1'b0, lo[c]} + {1'b0, hi[c]};
         mid[c] = sum[c][PIX_WIDTH:1];
      end
   end

   always_comb begin
      done    = 1'b0;
      result  = mid;
      t_next  = t;
      p_next  = p;
      lo_next = lo;
      hi_next = hi;
      priority if (t == '0) begin
         done   = 1'b1;
         result = lo;
      end else if (t >= p) begin
         done   = 1'b1;
         result = hi;
      end else if ({1'b0, t} > half_up) begin
         // upper half: move low end to the midpoint
         lo_next = mid;
         t_next  = t - half;
         p_next  = half;
      end else if (t < half) begin
         hi_next = mid;
         p_next  = half;
      end else begin
         done   = 1'b1;
         result = mid;
      end
   end

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// Crossfade blend core testbench
// Drives pixel pairs through the blend core at several row widths, predicts
// every output pixel and its row_end flag, and compares each response against
// the prediction. A directed table covers reset, degenerate and saturated
// widths and mid-row width changes; a random run follows with idle and stall
// phases on both channels.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import hcb_pkg::*;

   localparam int unsigned LIMIT_CYCLES  = 400000;
   localparam int unsigned SETTLE_CYCLES = 24;
   localparam int unsigned RANDOM_PIXELS = 1300;

   typedef logic [PIX_WIDTH-1:0] chan_val_type;

   typedef struct packed {
      chan_val_type a_red;
      chan_val_type a_green;
      chan_val_type a_blue;
      chan_val_type b_red;
      chan_val_type b_green;
      chan_val_type b_blue;
   } pixel_pair_type;

   typedef struct packed {
      chan_val_type red;
      chan_val_type green;
      chan_val_type blue;
      logic         row_end;
   } pixel_out_type;

   typedef enum logic {STEP_WIDTH, STEP_PIXEL} step_kind_type;

   typedef struct packed {
      step_kind_type         kind;
      logic [CFG_WIDTH-1:0]  width;
      pixel_pair_type        pair;
      logic                  pinned;
      pixel_out_type         want;
   } directed_step_type;

   localparam pixel_pair_type PAIR_ONE  = '{8'h00, 8'hFF, 8'h5A, 8'hFF, 8'h00, 8'hA5};
   localparam pixel_pair_type PAIR_TWO  = '{8'h80, 8'h01, 8'hFE, 8'h7F, 8'hFE, 8'h01};
   localparam pixel_pair_type PAIR_MID  = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF};
   localparam pixel_pair_type PAIR_LOW  = '{8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF};
   localparam pixel_pair_type PAIR_HIGH = '{8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00};
   localparam pixel_pair_type NO_PAIR   = '0;
   localparam pixel_out_type  NO_WANT   = '0;

   localparam int NUM_STEPS = 31;

   // Pinned rows carry a hand-computed result; the rest go through the predictor.
   directed_step_type directed_plan [NUM_STEPS] = '{
      '{STEP_PIXEL, 13'd0,    PAIR_ONE,  1'b1, '{8'h00, 8'hFF, 8'h5A, 1'b0}},
      '{STEP_WIDTH, 13'd0,    NO_PAIR,   1'b0, NO_WANT},
      '{STEP_PIXEL, 13'd0,    PAIR_TWO,  1'b1, '{8'h7F, 8'hFE, 8'h01, 1'b1}},
      '{STEP_PIXEL, 13'd0,    PAIR_ONE,  1'b1, '{8'h00, 8'hFF, 8'h5A, 1'b1}},
      '{STEP_WIDTH, 13'd1,    NO_PAIR,   1'b0, NO_WANT},
      '{STEP_PIXEL, 13'd0,    PAIR_TWO,  1'b1, '{8'h80, 8'h01, 8'hFE, 1'b1}},
      '{STEP_WIDTH, 13'd2,    NO_PAIR,   1'b0, NO_WANT},
      '{STEP_PIXEL, 13'd0,    PAIR_ONE,  1'b1, '{8'h00, 8'hFF, 8'h5A, 1'b0}},
      '{STEP_PIXEL, 13'd0,    PAIR_MID,  1'b1, '{8'h7F, 8'h7F, 8'h7F, 1'b1}},
      '{STEP_WIDTH, 13'd3,    NO_PAIR,   1'b0, NO_WANT},
      '{STEP_PIXEL, 13'd0,    PAIR_ONE,  1'b1, '{8'h00, 8'hFF, 8'h5A, 1'b0}},
      '{STEP_PIXEL, 13'd0,    PAIR_TWO,  1'b1, '{8'h80, 8'h01, 8'hFE, 1'b0}},
      '{STEP_PIXEL, 13'd0,    PAIR_ONE,  1'b1, '{8'hFF, 8'h00, 8'hA5, 1'b1}},
      '{STEP_WIDTH, 13'd8191, NO_PAIR,   1'b0, NO_WANT},
      '{STEP_PIXEL, 13'd0,    PAIR_TWO,  1'b1, '{8'h80, 8'h01, 8'hFE, 1'b0}},
      '{STEP_WIDTH, 13'd4097, NO_PAIR,   1'b0, NO_WANT},
      '{STEP_PIXEL, 13'd0,    PAIR_ONE,  1'b1, '{8'h00, 8'hFF, 8'h5A, 1'b0}},
      '{STEP_WIDTH, 13'd4096, NO_PAIR,   1'b0, NO_WANT},
      '{STEP_PIXEL, 13'd0,    PAIR_TWO,  1'b1, '{8'h80, 8'h01, 8'hFE, 1'b0}},
      '{STEP_WIDTH, 13'd6,    NO_PAIR,   1'b0, NO_WANT},
      '{STEP_PIXEL, 13'd0,    PAIR_LOW,  1'b0, NO_WANT},
      '{STEP_PIXEL, 13'd0,    PAIR_HIGH, 1'b0, NO_WANT},
      '{STEP_PIXEL, 13'd0,    PAIR_MID,  1'b0, NO_WANT},
      '{STEP_PIXEL, 13'd0,    PAIR_TWO,  1'b0, NO_WANT},
      '{STEP_PIXEL, 13'd0,    PAIR_LOW,  1'b0, NO_WANT},
      '{STEP_PIXEL, 13'd0,    PAIR_HIGH, 1'b0, NO_WANT},
      '{STEP_PIXEL, 13'd0,    PAIR_ONE,  1'b0, NO_WANT},
      '{STEP_WIDTH, 13'd9,    NO_PAIR,   1'b0, NO_WANT},
      '{STEP_PIXEL, 13'd0,    PAIR_LOW,  1'b0, NO_WANT},
      '{STEP_PIXEL, 13'd0,    PAIR_HIGH, 1'b0, NO_WANT},
      '{STEP_PIXEL, 13'd0,    PAIR_MID,  1'b0, NO_WANT}
   };

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CFG_WIDTH-1:0] csr_image_width = '0;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   chan_val_type         req_a_red = '0;
   chan_val_type         req_a_green = '0;
   chan_val_type         req_a_blue = '0;
   chan_val_type         req_b_red = '0;
   chan_val_type         req_b_green = '0;
   chan_val_type         req_b_blue = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   chan_val_type         rsp_out_red;
   chan_val_type         rsp_out_green;
   chan_val_type         rsp_out_blue;
   logic                 rsp_row_end;

   pixel_out_type        blend_expect [$];
   logic [CFG_WIDTH-1:0] width_reg;
   int unsigned          column_pos;
   logic                 pin_active = 1'b0;
   pixel_out_type        pin_want = '0;
   int unsigned          sender_idle_pct = 0;
   int unsigned          receiver_stall_pct = 0;
   int unsigned          cycle_count = 0;
   int unsigned          error_count = 0;
   int unsigned          pixels_sent = 0;
   int unsigned          results_checked = 0;
   int unsigned          rows_done = 0;
   int unsigned          widths_written = 0;

   horizontal_crossfade_blend_core uut (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_image_width (csr_image_width),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_a_red       (req_a_red),
      .req_a_green     (req_a_green),
      .req_a_blue      (req_a_blue),
      .req_b_red       (req_b_red),
      .req_b_green     (req_b_green),
      .req_b_blue      (req_b_blue),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_red     (rsp_out_red),
      .rsp_out_green   (rsp_out_green),
      .rsp_out_blue    (rsp_out_blue),
      .rsp_row_end     (rsp_row_end)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int unsigned effective_width(input logic [CFG_WIDTH-1:0] reg_val);
      int unsigned w;
      w = 32'(reg_val);
      if (w == 0) w = 1;
      if (w > DEFAULT_MAX_WIDTH) w = DEFAULT_MAX_WIDTH;
      return w;
   endfunction

   // Halve the scale each pass until the position lands on an end or the middle.
   function automatic chan_val_type ramp_value(input int unsigned lo, input int unsigned hi,
                                               input int unsigned pos, input int unsigned span);
      int unsigned mid;
      for (int pass = 0; pass < 64; pass++) begin
         mid = (lo + hi) >> 1;
         if (pos == 0) return lo[PIX_WIDTH-1:0];
         if (pos >= span) return hi[PIX_WIDTH-1:0];
         if (pos > ((span + 1) >> 1)) begin
            lo = mid;
            pos = pos - (span >> 1);
            span = span >> 1;
         end else if (pos < (span >> 1)) begin
            hi = mid;
            span = span >> 1;
         end else begin
            return mid[PIX_WIDTH-1:0];
         end
      end
      mid = (lo + hi) >> 1;
      return mid[PIX_WIDTH-1:0];
   endfunction

   function automatic pixel_out_type blend_pixel(input pixel_pair_type pair,
                                                 input int unsigned col,
                                                 input int unsigned eff_w);
      int unsigned   left_end;
      int unsigned   right_start;
      chan_val_type  a_chan [NUM_CHAN];
      chan_val_type  b_chan [NUM_CHAN];
      chan_val_type  mixed [NUM_CHAN];
      pixel_out_type res;
      left_end = eff_w / SPLIT_PARTS;
      right_start = eff_w - left_end;
      a_chan = '{pair.a_red, pair.a_green, pair.a_blue};
      b_chan = '{pair.b_red, pair.b_green, pair.b_blue};
      for (int c = 0; c < NUM_CHAN; c++) begin
         if (col < left_end) begin
            mixed[c] = a_chan[c];
         end else if (col >= right_start) begin
            mixed[c] = b_chan[c];
         end else begin
            mixed[c] = ramp_value(32'(a_chan[c]), 32'(b_chan[c]), col - left_end,
                                  right_start - left_end);
         end
      end
      res.red = mixed[0];
      res.green = mixed[1];
      res.blue = mixed[2];
      res.row_end = (col + 1 >= eff_w);
      return res;
   endfunction

   function automatic chan_val_type rand_chan();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return chan_val_type'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      $display("mismatch %s at result %0d, cycle %0d: got 0x%0h, expected 0x%0h",
               what, results_checked, cycle_count, got, want);
      error_count++;
   endtask

   // All driver tasks start and end just after a falling edge.
   task automatic send_pixel(input pixel_pair_type pair, input logic pinned,
                             input pixel_out_type want);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      pin_active = pinned;
      pin_want = want;
      req_valid <= 1'b1;
      req_a_red <= pair.a_red;
      req_a_green <= pair.a_green;
      req_a_blue <= pair.a_blue;
      req_b_red <= pair.b_red;
      req_b_green <= pair.b_green;
      req_b_blue <= pair.b_blue;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      pixels_sent++;
   endtask

   task automatic write_width(input logic [CFG_WIDTH-1:0] w);
      csr_valid <= 1'b1;
      csr_image_width <= w;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      widths_written++;
   endtask

   // Drop valid, let every pending pixel drain, then let the core settle.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (blend_expect.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d results still pending",
                  cycle_count, blend_expect.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   // Mirror the core: check the response transfer, then predict the request transfer.
   always @(posedge clock) begin
      pixel_out_type  want;
      pixel_pair_type pair;
      if (reset) begin
         column_pos = 0;
         width_reg = IMAGE_WIDTH_RESET;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (blend_expect.size() == 0) begin
               report_mismatch("result with nothing pending", 1, 0);
            end else begin
               want = blend_expect.pop_front();
               if (rsp_out_red !== want.red)
                  report_mismatch("out_red", 32'(rsp_out_red), 32'(want.red));
               if (rsp_out_green !== want.green)
                  report_mismatch("out_green", 32'(rsp_out_green), 32'(want.green));
               if (rsp_out_blue !== want.blue)
                  report_mismatch("out_blue", 32'(rsp_out_blue), 32'(want.blue));
               if (rsp_row_end !== want.row_end)
                  report_mismatch("row_end", 32'(rsp_row_end), 32'(want.row_end));
               results_checked++;
            end
         end
         if (csr_valid && csr_ready) width_reg = csr_image_width;
         if (req_valid && !req_stall) begin
            pair = '{req_a_red, req_a_green, req_a_blue, req_b_red, req_b_green, req_b_blue};
            want = blend_pixel(pair, column_pos, effective_width(width_reg));
            blend_expect.push_back(pin_active ? pin_want : want);
            if (want.row_end) begin
               column_pos = 0;
               rows_done++;
            end else begin
               column_pos = column_pos + 1;
            end
         end
      end
   end

   initial begin
      int unsigned          seg;
      int unsigned          random_goal;
      int unsigned          eff_w;
      int unsigned          burst;
      logic [CFG_WIDTH-1:0] new_width;
      pixel_pair_type       pair;

      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_plan[i]) begin
         if (directed_plan[i].kind == STEP_WIDTH) begin
            wait_idle();
            write_width(directed_plan[i].width);
         end else begin
            send_pixel(directed_plan[i].pair, directed_plan[i].pinned, directed_plan[i].want);
         end
      end

      random_goal = pixels_sent + RANDOM_PIXELS;
      seg = 0;
      while (pixels_sent < random_goal) begin
         wait_idle();
         case (seg % 4)
            0: begin
               sender_idle_pct = 0;
               receiver_stall_pct = 0;
            end
            1: begin
               sender_idle_pct = 47;
               receiver_stall_pct = 0;
            end
            2: begin
               sender_idle_pct = 0;
               receiver_stall_pct = 47;
            end
            default: begin
               sender_idle_pct = 16;
               receiver_stall_pct = 16;
            end
         endcase
         case ($urandom_range(0, 15))
            0:  new_width = '0;
            1:  new_width = 13'd1;
            2:  new_width = CFG_WIDTH'($urandom_range(2, 3));
            3, 4, 5, 6, 7, 8: new_width = CFG_WIDTH'($urandom_range(4, 40));
            9, 10, 11: new_width = CFG_WIDTH'($urandom_range(41, 160));
            12: new_width = CFG_WIDTH'($urandom_range(161, 260));
            13: new_width = CFG_WIDTH'(DEFAULT_MAX_WIDTH);
            default: new_width = $urandom_range(0, 1) ? '1
                                 : CFG_WIDTH'($urandom_range(4097, 8190));
         endcase
         write_width(new_width);
         eff_w = effective_width(new_width);
         // Keep the largest widths short; their bursts mostly land in the copy-A columns.
         if (eff_w <= 40) burst = 2 * eff_w + $urandom_range(0, eff_w) + 3;
         else if (eff_w <= 260) burst = eff_w + $urandom_range(0, 20);
         else burst = $urandom_range(8, 24);
         repeat (burst) begin
            pair = '{rand_chan(), rand_chan(), rand_chan(),
                     rand_chan(), rand_chan(), rand_chan()};
            send_pixel(pair, 1'b0, NO_WANT);
         end
         seg++;
      end

      wait_idle();
      $display("checked %0d blended pixels over %0d width writes and %0d random segments",
               results_checked, widths_written, seg);
      $display("completed %0d rows, %0d mismatches", rows_done, error_count);
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
